/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker module ckt_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, suspended during reset.
`define CKT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked at the next rising edge, suspended during reset.
`define CKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ckt_pkg.sv */
package ckt_pkg;

  localparam int CORNERS = 4;
  localparam int AXES = 2 * CORNERS;
  localparam int LANES_DEFAULT = 4;
  localparam int CFG_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W = 15;
  localparam int EST_W = 16;
  localparam int ST_W = 40;
  localparam int DIV_BITS = 56;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COVARIANCE = 2'd2;

  localparam logic [CFG_W-1:0] PROCESS_NOISE_RESET = 24'd3277;
  localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RESET = 24'd52429;
  localparam logic [CFG_W-1:0] INITIAL_COVARIANCE_RESET = 24'd65536;

  typedef logic signed [ST_W-1:0] st_t;

  typedef struct packed {
    st_t pos;
    st_t vel;
    st_t cpp;
    st_t cpv;
    st_t cvv;
  } axis_state_t;

  typedef struct packed {
    logic start;
    logic seed;
    logic meas;
  } lane_cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] q;
    logic [CFG_W-1:0] r;
    logic [CFG_W-1:0] p0;
  } cfg_t;

  function automatic st_t sat40(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd549755813887;
    lo = -48'sd549755813888;
    if (v > hi) return st_t'(hi);
    if (v < lo) return st_t'(lo);
    return st_t'(v);
  endfunction

  function automatic logic signed [EST_W-1:0] out_coord(input st_t p);
    logic signed [ST_W:0] e;
    logic signed [ST_W-12:0] s;
    e = {p[ST_W-1], p} + (ST_W+1)'(2048);
    s = e[ST_W:12];
    if (s > 29'sd32767) return 16'sh7fff;
    if (s < -29'sd32768) return 16'sh8000;
    return s[EST_W-1:0];
  endfunction

endpackage

/* hw/rtl/ckt_if.sv */
interface ckt_in_if;
  logic valid;
  logic ready;
  logic detected;
  logic [ckt_pkg::COORD_W-1:0] c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y;
  modport source(output valid, detected, c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y,
                 input ready);
  modport sink(input valid, detected, c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y,
               output ready);
endinterface

interface ckt_out_if;
  logic valid;
  logic ready;
  logic tracking;
  logic signed [ckt_pkg::EST_W-1:0] e0_x, e0_y, e1_x, e1_y, e2_x, e2_y, e3_x, e3_y;
  modport source(output valid, tracking, e0_x, e0_y, e1_x, e1_y, e2_x, e2_y, e3_x, e3_y,
                 input ready);
  modport sink(input valid, tracking, e0_x, e0_y, e1_x, e1_y, e2_x, e2_y, e3_x, e3_y,
               output ready);
endinterface

/* hw/rtl/ckt_lane.sv */
// One corner lane: x and y axis filters run in turn through one shared sequencer,
// a shared 22x41 multiplier and a restoring divider that yields one quotient bit a cycle.
module ckt_lane (
  input  logic clk,
  input  logic rst,
  input  ckt_pkg::lane_cmd_t cmd,
  input  ckt_pkg::cfg_t cfg,
  input  logic [ckt_pkg::COORD_W-1:0] z_x,
  input  logic [ckt_pkg::COORD_W-1:0] z_y,
  output logic done,
  output ckt_pkg::st_t pos_x,
  output ckt_pkg::st_t pos_y
);

  typedef enum logic [3:0] {
    S_IDLE, S_PRED, S_CHK, S_DIV0, S_DIV1, S_MULP, S_MULV, S_MUL0, S_MUL1, S_MUL2,
    S_WB, S_NEXT
  } state_t;

  state_t state;
  logic ax;
  logic meas;
  ckt_pkg::axis_state_t st [2];
  ckt_pkg::st_t p, v, pa, pb, pc;
  logic signed [ckt_pkg::ST_W:0] innov;
  logic signed [47:0] s_reg;
  logic [47:0] rem;
  logic [ckt_pkg::DIV_BITS-1:0] quo;
  logic [63:0] num;
  logic [5:0] bitn;
  logic sel_k1;
  logic neg0, neg1;
  logic signed [21:0] k0, k1;
  logic signed [47:0] np, nv, na, nb, nc;

  logic [ckt_pkg::COORD_W-1:0] z;
  logic [ckt_pkg::COORD_W-1:0] zx_r, zy_r;
  logic signed [47:0] pred_p, pred_a, pred_b, pred_c;
  logic signed [47:0] sq;
  logic [47:0] trial;
  logic signed [21:0] kq;
  logic signed [21:0] mk;
  logic signed [ckt_pkg::ST_W:0] mx;
  logic signed [62:0] prod;
  logic signed [47:0] prod_r;

  assign z = ax ? zy_r : zx_r;
  assign pos_x = st[0].pos;
  assign pos_y = st[1].pos;

  always_comb begin
    pred_p = 48'(st[ax].pos) + 48'(st[ax].vel);
    pred_a = 48'(st[ax].cpp) + 48'(st[ax].cpv) + 48'(st[ax].cpv) + 48'(st[ax].cvv)
             + 48'(signed'({1'b0, cfg.q}));
    pred_b = 48'(st[ax].cpv) + 48'(st[ax].cvv);
    pred_c = 48'(st[ax].cvv) + 48'(signed'({1'b0, cfg.q}));
    sq = 48'(pa) + 48'(signed'({1'b0, cfg.r}));
    trial = {rem[46:0], num[63]};
    if (quo > ckt_pkg::DIV_BITS'(1 << 20)) begin
      kq = 22'sd1048576;
    end else begin
      kq = 22'(quo);
    end
    case (state)
      S_MULP: begin mk = k0; mx = innov; end
      S_MULV: begin mk = k1; mx = innov; end
      S_MUL0: begin mk = k0; mx = (ckt_pkg::ST_W+1)'(pa); end
      S_MUL1: begin mk = k0; mx = (ckt_pkg::ST_W+1)'(pb); end
      default: begin mk = k1; mx = (ckt_pkg::ST_W+1)'(pb); end
    endcase
    prod = 63'(mk) * 63'(mx) + 63'sd32768;
    prod_r = 48'(prod >>> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      ax <= 1'b0;
      meas <= 1'b0;
      for (int i = 0; i < 2; i++) st[i] <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            ax <= 1'b0;
            meas <= cmd.meas;
            zx_r <= z_x;
            zy_r <= z_y;
            if (cmd.seed) begin
              st[0] <= {ckt_pkg::st_t'({z_x, 12'd0}), ckt_pkg::st_t'(0),
                        ckt_pkg::st_t'(cfg.p0), ckt_pkg::st_t'(0), ckt_pkg::st_t'(cfg.p0)};
              st[1] <= {ckt_pkg::st_t'({z_y, 12'd0}), ckt_pkg::st_t'(0),
                        ckt_pkg::st_t'(cfg.p0), ckt_pkg::st_t'(0), ckt_pkg::st_t'(cfg.p0)};
            end
            state <= S_PRED;
          end
        end
        S_PRED: begin
          p <= ckt_pkg::sat40(pred_p);
          v <= st[ax].vel;
          pa <= ckt_pkg::sat40(pred_a);
          pb <= ckt_pkg::sat40(pred_b);
          pc <= ckt_pkg::sat40(pred_c);
          state <= meas ? S_CHK : S_WB;
        end
        S_CHK: begin
          s_reg <= sq;
          innov <= (ckt_pkg::ST_W+1)'(48'(signed'({1'b0, z, 12'd0})) - 48'(p));
          if (sq > 0) begin
            sel_k1 <= 1'b0;
            neg0 <= pa[ckt_pkg::ST_W-1];
            num <= 64'({pa[ckt_pkg::ST_W-1] ? -48'(pa) : 48'(pa), 16'd0});
            rem <= '0;
            quo <= '0;
            bitn <= '0;
            state <= S_DIV0;
          end else begin
            state <= S_WB;
          end
        end
        S_DIV0: begin
          if (trial >= 48'(s_reg)) begin
            rem <= trial - 48'(s_reg);
            quo <= {quo[ckt_pkg::DIV_BITS-2:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[ckt_pkg::DIV_BITS-2:0], 1'b0};
          end
          num <= {num[62:0], 1'b0};
          bitn <= bitn + 6'd1;
          if (bitn == 6'd63) state <= S_DIV1;
        end
        S_DIV1: begin
          if (!sel_k1) begin
            k0 <= neg0 ? -kq : kq;
            sel_k1 <= 1'b1;
            neg1 <= pb[ckt_pkg::ST_W-1];
            num <= 64'({pb[ckt_pkg::ST_W-1] ? -48'(pb) : 48'(pb), 16'd0});
            rem <= '0;
            quo <= '0;
            bitn <= '0;
            state <= S_DIV0;
          end else begin
            k1 <= neg1 ? -kq : kq;
            state <= S_MULP;
          end
        end
        S_MULP: begin np <= 48'(p) + prod_r; state <= S_MULV; end
        S_MULV: begin nv <= 48'(v) + prod_r; state <= S_MUL0; end
        S_MUL0: begin na <= 48'(pa) - prod_r; state <= S_MUL1; end
        S_MUL1: begin nb <= 48'(pb) - prod_r; state <= S_MUL2; end
        S_MUL2: begin
          p <= ckt_pkg::sat40(np);
          v <= ckt_pkg::sat40(nv);
          pa <= ckt_pkg::sat40(na);
          pb <= ckt_pkg::sat40(nb);
          pc <= ckt_pkg::sat40(48'(pc) - prod_r);
          state <= S_WB;
        end
        S_WB: begin
          st[ax] <= {p, v, pa, pb, pc};
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (!ax) begin
            ax <= 1'b1;
            state <= S_PRED;
          end else begin
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/ckt_merge.sv */
// Rounds and saturates lane positions; zeros when not tracking.
module ckt_merge #(
  parameter int LANES = ckt_pkg::LANES_DEFAULT
) (
  input  logic clk,
  input  logic load,
  input  logic trk,
  input  ckt_pkg::st_t pos [LANES][2],
  output logic tracking,
  output logic signed [ckt_pkg::EST_W-1:0] est [ckt_pkg::CORNERS][2]
);

  localparam int NL = (LANES < ckt_pkg::CORNERS) ? LANES : ckt_pkg::CORNERS;

  always_ff @(posedge clk) begin
    if (load) begin
      tracking <= trk;
      for (int c = 0; c < ckt_pkg::CORNERS; c++) begin
        for (int a = 0; a < 2; a++) begin
          if (c < NL && trk) est[c][a] <= ckt_pkg::out_coord(pos[c][a]);
          else est[c][a] <= '0;
        end
      end
    end
  end

endmodule

/* hw/rtl/corner_kalman_tracker_unit.sv */
// Channel   Direction  Payload
// in_ch     sink       detected, c0_x .. c3_y (15 bit each)
// out_ch    source     tracking, e0_x .. e3_y (16 bit signed each)
// cfg       write      cfg_we, cfg_idx, cfg_data (24 bit)
// For a detected frame each lane runs its two axes in turn, each through two 64-step
// serial gain divisions if pa + r > 0; a seeded predict-only frame skips them, and
// a frame before the first detection starts no lane and goes straight to the merge.
// Reset is synchronous and clears the filter state and the seeded flag.
// One request is in flight at a time; a stalled result holds the next request off.
module corner_kalman_tracker_unit #(
  parameter int LANES = ckt_pkg::LANES_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  ckt_in_if.sink in_ch,
  ckt_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [ckt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ckt_pkg::CFG_W-1:0] cfg_data
);

  localparam int NL = (LANES < ckt_pkg::CORNERS) ? LANES : ckt_pkg::CORNERS;

  typedef enum logic [1:0] {T_IDLE, T_RUN, T_MERGE, T_OUT} tstate_t;

  tstate_t state;
  ckt_pkg::cfg_t cfg;
  logic seeded;
  logic [ckt_pkg::COORD_W-1:0] zin [ckt_pkg::CORNERS][2];
  ckt_pkg::lane_cmd_t cmd;
  logic [NL-1:0] lane_done;
  logic [NL-1:0] fin;
  ckt_pkg::st_t pos [NL][2];
  logic signed [ckt_pkg::EST_W-1:0] est [ckt_pkg::CORNERS][2];
  logic tracking;
  logic load;
  logic accept;

  assign in_ch.ready = (state == T_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign zin[0][0] = in_ch.c0_x;
  assign zin[0][1] = in_ch.c0_y;
  assign zin[1][0] = in_ch.c1_x;
  assign zin[1][1] = in_ch.c1_y;
  assign zin[2][0] = in_ch.c2_x;
  assign zin[2][1] = in_ch.c2_y;
  assign zin[3][0] = in_ch.c3_x;
  assign zin[3][1] = in_ch.c3_y;

  always_comb begin
    cmd.start = accept && (in_ch.detected || seeded);
    cmd.seed = in_ch.detected && !seeded;
    cmd.meas = in_ch.detected;
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    ckt_lane u_lane (
      .clk(clk), .rst(rst), .cmd(cmd), .cfg(cfg),
      .z_x(zin[l][0]), .z_y(zin[l][1]),
      .done(lane_done[l]), .pos_x(pos[l][0]), .pos_y(pos[l][1])
    );
  end

  assign load = (state == T_MERGE);

  ckt_merge #(.LANES(NL)) u_merge (
    .clk(clk), .load(load), .trk(seeded), .pos(pos),
    .tracking(tracking), .est(est)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      seeded <= 1'b0;
      fin <= '0;
      cfg <= {ckt_pkg::PROCESS_NOISE_RESET, ckt_pkg::MEASUREMENT_NOISE_RESET,
              ckt_pkg::INITIAL_COVARIANCE_RESET};
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          ckt_pkg::REG_PROCESS_NOISE: cfg.q <= cfg_data;
          ckt_pkg::REG_MEASUREMENT_NOISE: cfg.r <= cfg_data;
          ckt_pkg::REG_INITIAL_COVARIANCE: cfg.p0 <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            if (cmd.start) begin
              seeded <= 1'b1;
              fin <= '0;
              state <= T_RUN;
            end else begin
              state <= T_MERGE;
            end
          end
        end
        T_RUN: begin
          if (&(fin | lane_done)) state <= T_MERGE;
          else fin <= fin | lane_done;
        end
        T_MERGE: state <= T_OUT;
        T_OUT: if (out_ch.ready) state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end

  assign out_ch.valid = (state == T_OUT);
  assign out_ch.tracking = tracking;
  assign out_ch.e0_x = est[0][0];
  assign out_ch.e0_y = est[0][1];
  assign out_ch.e1_x = est[1][0];
  assign out_ch.e1_y = est[1][1];
  assign out_ch.e2_x = est[2][0];
  assign out_ch.e2_y = est[2][1];
  assign out_ch.e3_x = est[3][0];
  assign out_ch.e3_y = est[3][1];

endmodule

/* hw/rtl/ckt_checker.sv */
`include "assert_macros.svh"

module ckt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic tracking,
  input logic signed [15:0] e0_x
);

  `CKT_ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready, "request taken while result pending")
  `CKT_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(e0_x), "result dropped")
  `CKT_ASSERT_IMP(a_zero, clk, rst, out_valid && !tracking, e0_x == 16'sd0, "estimate while not tracking")
  `CKT_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "second request accepted at once")

endmodule

bind corner_kalman_tracker_unit ckt_checker u_ckt_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .tracking(out_ch.tracking),
  .e0_x(out_ch.e0_x)
);

/* dv/corner_kalman_tracker_unit_test.sv */
module corner_kalman_tracker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit det;
    logic [ckt_pkg::COORD_W-1:0] c [ckt_pkg::AXES];
  } frame_t;

  typedef struct {
    logic trk;
    logic signed [ckt_pkg::EST_W-1:0] e [ckt_pkg::AXES];
  } estimate_t;

  class corner_track_scoreboard;
    longint q, r, p0;
    bit seeded;
    longint pos [ckt_pkg::AXES];
    longint vel [ckt_pkg::AXES];
    longint cpp [ckt_pkg::AXES];
    longint cpv [ckt_pkg::AXES];
    longint cvv [ckt_pkg::AXES];
    estimate_t pending [$];
    int errors;

    function new();
      q = longint'(ckt_pkg::PROCESS_NOISE_RESET);
      r = longint'(ckt_pkg::MEASUREMENT_NOISE_RESET);
      p0 = longint'(ckt_pkg::INITIAL_COVARIANCE_RESET);
      seeded = 0;
      errors = 0;
      foreach (pos[i]) begin
        pos[i] = 0; vel[i] = 0; cpp[i] = 0; cpv[i] = 0; cvv[i] = 0;
      end
    endfunction

    function void set_reg(logic [ckt_pkg::CFG_IDX_W-1:0] idx, logic [ckt_pkg::CFG_W-1:0] val);
      case (idx)
        ckt_pkg::REG_PROCESS_NOISE: q = longint'(val);
        ckt_pkg::REG_MEASUREMENT_NOISE: r = longint'(val);
        ckt_pkg::REG_INITIAL_COVARIANCE: p0 = longint'(val);
        default: ;
      endcase
    endfunction

    function longint clamp40(longint v);
      if (v > 64'sd549755813887) return 64'sd549755813887;
      if (v < -64'sd549755813888) return -64'sd549755813888;
      return v;
    endfunction

    function longint scale_gain(longint k, longint x);
      return (k * x + 64'sd32768) >>> 16;
    endfunction

    function longint gain_of(longint num, longint den);
      longint k;
      k = (num * 65536) / den;
      if (k > 64'sd1048576) return 64'sd1048576;
      if (k < -64'sd1048576) return -64'sd1048576;
      return k;
    endfunction

    function void filter_axis(int i, bit meas, longint z);
      longint p, v, pa, pb, pc, s, k0, k1, innov, na, nb, nc;
      p = clamp40(pos[i] + vel[i]);
      v = vel[i];
      pa = clamp40(cpp[i] + 2 * cpv[i] + cvv[i] + q);
      pb = clamp40(cpv[i] + cvv[i]);
      pc = clamp40(cvv[i] + q);
      if (meas) begin
        s = pa + r;
        if (s > 0) begin
          k0 = gain_of(pa, s);
          k1 = gain_of(pb, s);
          innov = z - p;
          p = clamp40(p + scale_gain(k0, innov));
          v = clamp40(v + scale_gain(k1, innov));
          na = clamp40(pa - scale_gain(k0, pa));
          nb = clamp40(pb - scale_gain(k0, pb));
          nc = clamp40(pc - scale_gain(k1, pb));
          pa = na; pb = nb; pc = nc;
        end
      end
      pos[i] = p; vel[i] = v; cpp[i] = pa; cpv[i] = pb; cvv[i] = pc;
    endfunction

    function logic signed [ckt_pkg::EST_W-1:0] to_pixels(longint p);
      longint e;
      e = (p + 64'sd2048) >>> 12;
      if (e > 32767) e = 32767;
      if (e < -32768) e = -32768;
      return e[ckt_pkg::EST_W-1:0];
    endfunction

    function void note_request(frame_t f);
      estimate_t x;
      x.trk = 0;
      foreach (x.e[i]) x.e[i] = '0;
      if (f.det || seeded) begin
        if (f.det && !seeded) begin
          foreach (pos[i]) begin
            pos[i] = longint'(f.c[i]) <<< 12;
            vel[i] = 0; cpp[i] = p0; cpv[i] = 0; cvv[i] = p0;
          end
          seeded = 1;
        end
        foreach (pos[i]) begin
          filter_axis(i, f.det, longint'(f.c[i]) <<< 12);
          x.e[i] = to_pixels(pos[i]);
        end
        x.trk = 1;
      end
      pending.insert(pending.size(), x);
    endfunction

    function void check_result(estimate_t got);
      estimate_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, tracking %b e0_x %0d", $time, got.trk, got.e[0]);
        errors++;
        return;
      end
      x = pending[0];
      pending.delete(0);
      if (got.trk !== x.trk) begin
        $display("%0t: tracking expected %b actual %b", $time, x.trk, got.trk);
        errors++;
      end
      foreach (x.e[i])
        if (got.e[i] !== x.e[i]) begin
          $display("%0t: e%0d_%s expected %0d actual %0d", $time, i / 2,
                   (i % 2) ? "y" : "x", x.e[i], got.e[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [ckt_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [ckt_pkg::CFG_W-1:0] cfg_data = '0;
  bit steady;
  corner_track_scoreboard sb;

  ckt_in_if in_ch ();
  ckt_out_if out_ch ();

  corner_kalman_tracker_unit uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.detected = 0;
    {in_ch.c0_x, in_ch.c0_y, in_ch.c1_x, in_ch.c1_y} = '0;
    {in_ch.c2_x, in_ch.c2_y, in_ch.c3_x, in_ch.c3_y} = '0;
    out_ch.ready = 0;
  end

  function automatic int pause_len();
    int k;
    if (steady) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  always @(negedge clk) begin
    int n;
    if (rst) begin
      out_ch.ready <= 0;
    end else begin
      n = pause_len();
      out_ch.ready <= (n == 0);
    end
  end

  always @(posedge clk) begin
    estimate_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.trk = out_ch.tracking;
      got.e[0] = out_ch.e0_x; got.e[1] = out_ch.e0_y;
      got.e[2] = out_ch.e1_x; got.e[3] = out_ch.e1_y;
      got.e[4] = out_ch.e2_x; got.e[5] = out_ch.e2_y;
      got.e[6] = out_ch.e3_x; got.e[7] = out_ch.e3_y;
      sb.check_result(got);
    end
  end

  task automatic send_frame(frame_t f);
    int n;
    n = pause_len();
    repeat (n) @(negedge clk);
    in_ch.valid = 1;
    in_ch.detected = f.det;
    in_ch.c0_x = f.c[0]; in_ch.c0_y = f.c[1];
    in_ch.c1_x = f.c[2]; in_ch.c1_y = f.c[3];
    in_ch.c2_x = f.c[4]; in_ch.c2_y = f.c[5];
    in_ch.c3_x = f.c[6]; in_ch.c3_y = f.c[7];
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(f);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic write_reg(logic [ckt_pkg::CFG_IDX_W-1:0] idx,
                           logic [ckt_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic frame_t flat_frame(bit det, logic [ckt_pkg::COORD_W-1:0] v);
    frame_t f;
    f.det = det;
    foreach (f.c[i]) f.c[i] = v;
    return f;
  endfunction

  function automatic frame_t noise_frame();
    frame_t f;
    f.det = $urandom_range(0, 3) != 0;
    foreach (f.c[i]) f.c[i] = ckt_pkg::COORD_W'($urandom());
    return f;
  endfunction

  task automatic run_tracks(int count);
    int base [ckt_pkg::AXES];
    int speed [ckt_pkg::AXES];
    frame_t f;
    int v;
    foreach (base[i]) begin
      base[i] = $urandom_range(0, 32767);
      speed[i] = $urandom_range(0, 1) ? $urandom_range(0, 64) - 32 : $urandom_range(0, 800) - 400;
    end
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        f = noise_frame();
      end else begin
        f.det = $urandom_range(0, 5) != 0;
        foreach (base[i]) begin
          base[i] += speed[i];
          if (base[i] < 0 || base[i] > 32767) begin
            speed[i] = -speed[i];
            base[i] = (base[i] < 0) ? 0 : 32767;
          end
          v = base[i] + $urandom_range(0, 40) - 20;
          if (v < 0) v = 0;
          if (v > 32767) v = 32767;
          f.c[i] = ckt_pkg::COORD_W'(v);
        end
      end
      send_frame(f);
    end
  endtask

  initial begin
    frame_t f;
    sb = new();
    steady = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_frame(flat_frame(0, 15'h7fff));
    send_frame(flat_frame(0, 15'h0));
    send_frame(flat_frame(1, 15'h7fff));
    send_frame(flat_frame(0, 15'h0));
    send_frame(flat_frame(1, 15'h0));
    send_frame(flat_frame(1, 15'h7fff));
    send_frame(flat_frame(1, 15'h7fff));
    send_frame(flat_frame(0, 15'h0));
    send_frame(flat_frame(0, 15'h0));
    for (int k = 0; k < 4; k++) begin
      f.det = 1;
      foreach (f.c[i]) f.c[i] = (i % 2) ? 15'h7fff : 15'h0;
      if (k % 2) foreach (f.c[i]) f.c[i] = ~f.c[i];
      send_frame(f);
    end
    for (int k = 0; k < 4; k++) send_frame(flat_frame(0, 15'h5555));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      steady = (ph == 3);
      case (ph)
        0: begin
          write_reg(ckt_pkg::REG_PROCESS_NOISE, 24'd0);
          write_reg(ckt_pkg::REG_MEASUREMENT_NOISE, 24'd1);
          write_reg(ckt_pkg::REG_INITIAL_COVARIANCE, 24'd0);
        end
        1: begin
          write_reg(ckt_pkg::REG_PROCESS_NOISE, 24'hffffff);
          write_reg(ckt_pkg::REG_MEASUREMENT_NOISE, 24'hffffff);
          write_reg(ckt_pkg::REG_INITIAL_COVARIANCE, 24'hffffff);
        end
        2: begin
          write_reg(ckt_pkg::REG_PROCESS_NOISE, 24'd0);
          write_reg(ckt_pkg::REG_MEASUREMENT_NOISE, 24'hffffff);
          write_reg(ckt_pkg::REG_INITIAL_COVARIANCE, 24'd0);
        end
        3: begin
          write_reg(ckt_pkg::REG_PROCESS_NOISE, ckt_pkg::PROCESS_NOISE_RESET);
          write_reg(ckt_pkg::REG_MEASUREMENT_NOISE, ckt_pkg::MEASUREMENT_NOISE_RESET);
          write_reg(ckt_pkg::REG_INITIAL_COVARIANCE, ckt_pkg::INITIAL_COVARIANCE_RESET);
        end
        default: begin
          write_reg(ckt_pkg::REG_PROCESS_NOISE,
                    ckt_pkg::CFG_W'($urandom_range(0, 24'hffffff)));
          write_reg(ckt_pkg::REG_MEASUREMENT_NOISE,
                    ckt_pkg::CFG_W'($urandom_range(1, 24'hffffff)));
          write_reg(ckt_pkg::REG_INITIAL_COVARIANCE,
                    ckt_pkg::CFG_W'($urandom_range(0, 24'hffffff)));
        end
      endcase
      run_tracks(105);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
